@@ sv/xor_reverse_byte_scrambler_assert.svh @@
// Assertion macros for the byte scrambler. Empty bodies under SYNTHESIS.
`ifndef XOR_REVERSE_BYTE_SCRAMBLER_ASSERT_SVH
`define XOR_REVERSE_BYTE_SCRAMBLER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define XRBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xrbs: same-cycle check failed");
// Next-cycle implication
`define XRBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xrbs: next-cycle check failed");
`else
`define XRBS_ASSERT_IMP(lbl, ante, cons)
`define XRBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/xrbs_pkg.sv @@
`default_nettype none

package xrbs_pkg;

  // Number of stack cells
  localparam int DEPTH = 64;
  // Fill count must hold DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [7:0] byte_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Shift command to the cell row
  typedef struct packed {
    logic push;  // every cell takes its upper neighbor
    logic pop;   // every cell takes its lower neighbor
  } shift_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic flush;
    cnt_t count;
  } status_t;

endpackage

`default_nettype wire

@@ sv/xrbs_cell.sv @@
`default_nettype none

// One stack entry: shifts down on push, up on pop, holds otherwise.
module xrbs_cell (
  input  wire logic            clk,
  input  wire xrbs_pkg::shift_t shift,
  input  wire xrbs_pkg::byte_t upper,
  input  wire xrbs_pkg::byte_t lower,
  output xrbs_pkg::byte_t      q
);

  always_ff @(posedge clk) begin
    if (shift.push) begin
      q <= upper;
    end else if (shift.pop) begin
      q <= lower;
    end
  end

endmodule

`default_nettype wire

@@ sv/xrbs_ctrl.sv @@
`default_nettype none

// Stack control: fill count, drop flag, load/flush sequencing, output register.
module xrbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire xrbs_pkg::byte_t   cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire xrbs_pkg::byte_t   in_byte,
  input  wire logic              in_eom,
  input  wire xrbs_pkg::byte_t   top_byte,
  output xrbs_pkg::byte_t        push_byte,
  output xrbs_pkg::shift_t       shift,
  output xrbs_pkg::status_t      status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output xrbs_pkg::byte_t        out_byte,
  output logic                   out_last,
  output logic                   out_dropped
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic            state;
  xrbs_pkg::cnt_t  count;
  logic            overflow;
  xrbs_pkg::byte_t xor_key;
  logic            in_fire;
  logic            room;

  // Key register
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key <= '0;
    end else if (cfg_wr_en) begin
      xor_key <= cfg_wr_data;
    end
  end

  assign push_byte = in_byte ^ xor_key;
  assign in_ready  = (state == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign room      = (count < xrbs_pkg::cnt_t'(xrbs_pkg::DEPTH));

  // Shift commands; pop only into a free output register
  assign shift.push = in_fire && room;
  assign shift.pop  = (state == ST_FLUSH) && (!out_valid || out_ready);

  assign status.flush = (state == ST_FLUSH);
  assign status.count = count;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (shift.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (room) begin
              count <= count + xrbs_pkg::cnt_t'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (in_eom) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (shift.pop) begin
            count <= count - xrbs_pkg::cnt_t'(1);
            if (count == xrbs_pkg::cnt_t'(1)) begin
              state    <= ST_LOAD;
              overflow <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (shift.pop) begin
      out_byte    <= top_byte;
      out_last    <= (count == xrbs_pkg::cnt_t'(1));
      out_dropped <= overflow;
    end
  end

endmodule

`default_nettype wire

@@ sv/xor_reverse_byte_scrambler.sv @@
// XOR key scrambler with reversal. Input stream: s_axis_tdata is a message
// byte, s_axis_tlast marks the final byte. Each accepted byte is XORed with
// the key and, if the stack has room, pushed onto a stack made of a row of
// shifting cells. After the end-marked byte the input stalls (s_axis_tready
// low) while the stored bytes leave on m_axis in reverse order, one per
// cycle while the receiver is ready, m_axis_tlast on the final one and
// m_axis_tuser set on all of them if any byte was dropped because the stack
// was full. Once the end byte is taken the state turns to flush and the
// first pop loads the output register; input resumes the cycle after the
// final pop. A stalled receiver holds the output register and the flush
// waits with it. The user must write the key on cfg_wr_en only while idle;
// the block does not enforce it. Reset clears the key, fill count, drop flag
// and output valid; the stack contents are not cleared and need no clearing.
`default_nettype none

`include "xor_reverse_byte_scrambler_assert.svh"

module xor_reverse_byte_scrambler (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // end_of_message
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // out_last
  output logic            m_axis_tuser    // [0] bytes_dropped
);

  xrbs_pkg::byte_t   push_byte;
  xrbs_pkg::shift_t  shift;
  xrbs_pkg::status_t status;
  xrbs_pkg::byte_t   cell_q [xrbs_pkg::DEPTH];

  // Controller
  xrbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .in_eom      (s_axis_tlast),
    .top_byte    (cell_q[0]),
    .push_byte   (push_byte),
    .shift       (shift),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .out_dropped (m_axis_tuser)
  );

  // Cell row: cell 0 is the top of the stack
  for (genvar i = 0; i < xrbs_pkg::DEPTH; i++) begin : g_cell
    xrbs_pkg::byte_t upper;
    xrbs_pkg::byte_t lower;
    if (i == 0) begin : g_first
      assign upper = push_byte;
    end else begin : g_mid_up
      assign upper = cell_q[i-1];
    end
    if (i == xrbs_pkg::DEPTH - 1) begin : g_last
      assign lower = cell_q[i];
    end else begin : g_mid_dn
      assign lower = cell_q[i+1];
    end
    xrbs_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .upper (upper),
      .lower (lower),
      .q     (cell_q[i])
    );
  end

  // Checks
  `XRBS_ASSERT_IMP(a_count_bound, 1'b1, status.count <= xrbs_pkg::cnt_t'(xrbs_pkg::DEPTH))
  `XRBS_ASSERT_IMP(a_flush_nonempty, status.flush, status.count != '0)
  `XRBS_ASSERT_IMP(a_no_push_pop, 1'b1, !(shift.push && shift.pop))
  `XRBS_ASSERT_NEXT(a_flush_emits, status.flush && !m_axis_tvalid, m_axis_tvalid)
  `XRBS_ASSERT_NEXT(a_push_count, shift.push, status.count == $past(status.count) + xrbs_pkg::cnt_t'(1))

endmodule

`default_nettype wire
